// ----- hdl/hv_triangle_ramp_checker_macros.svh -----
// assertion macros for the high-voltage triangle ramp checker
`ifndef HV_TRIANGLE_RAMP_CHECKER_MACROS_SVH
`define HV_TRIANGLE_RAMP_CHECKER_MACROS_SVH

// same-cycle implication, sampled on clk, quiet during rst
`define HVTRC_ASSERT_NOW(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (con)) else $error(msg);

// next-cycle implication, sampled on clk, quiet during rst
`define HVTRC_ASSERT_NEXT(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (con)) else $error(msg);

`endif

// ----- hdl/hvtrc_pkg.sv -----
// shared constants, types and helpers for the high-voltage triangle ramp checker
package hvtrc_pkg;

  localparam int LEVEL_BITS      = 12;
  localparam int VOLT_BITS       = 11;
  localparam int MV_BITS         = 21;
  localparam int RD_BITS         = 12;
  localparam int CFG_IDX_BITS    = 2;

  localparam int FULL_VOLT       = 2047;
  localparam int MV_PER_VOLT     = 1000;
  localparam int LEVELS_PER_VOLT = 2;
  localparam int MV_PER_LEVEL    = MV_PER_VOLT / LEVELS_PER_VOLT;
  localparam int PASS_LIMIT      = 4;

  localparam int IN_DATA_BITS    = 16;
  localparam int OUT_DATA_BITS   = 64;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_MIN_VOLT  = 2'd0,
    REG_MAX_VOLT  = 2'd1,
    REG_STEP_VOLT = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    CMD_START  = 1'b0,
    CMD_SAMPLE = 1'b1
  } cmd_t;

  typedef logic [LEVEL_BITS-1:0] level_t;
  typedef logic [VOLT_BITS-1:0]  volt_t;
  typedef logic [MV_BITS-1:0]    mv_t;

  typedef struct packed {
    volt_t min_volt;
    volt_t max_volt;
    volt_t step_volt;
  } cfg_t;

  typedef struct packed {
    logic   pass_flag;
    logic   finished;
    mv_t    worst_read_mv;
    mv_t    worst_set_mv;
    logic   hv_enable;
    level_t dac_level;
  } result_t;

  typedef struct packed {
    level_t set_level;
    level_t low_level;
    level_t high_level;
    logic   ramp_done;
    logic   enable_on;
  } ramp_status_t;

  // volts to half-volt levels
  function automatic level_t volt_to_level(input volt_t v);
    level_t l;
    l = {v, 1'b0};
    return l;
  endfunction

  // half-volt levels to millivolts
  function automatic mv_t level_to_mv(input level_t l);
    mv_t m;
    m = MV_BITS'(l) * MV_BITS'(MV_PER_LEVEL);
    return m;
  endfunction

endpackage

// ----- hdl/hvtrc_cfg.sv -----
// configuration registers: ramp bounds and step
module hvtrc_cfg import hvtrc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  volt_t                   cfg_data,
  output cfg_t                    cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_volt  <= '0;
      cfg.max_volt  <= VOLT_BITS'(FULL_VOLT);
      cfg.step_volt <= VOLT_BITS'(1);
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_MIN_VOLT:  cfg.min_volt  <= cfg_data;
        REG_MAX_VOLT:  cfg.max_volt  <= cfg_data;
        REG_STEP_VOLT: cfg.step_volt <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ----- hdl/hvtrc_ramp.sv -----
// ramp state, worst-error tracking and next-result logic
module hvtrc_ramp import hvtrc_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  cfg_t          cfg,
  input  logic          advance,
  input  logic          cmd,
  input  level_t        rd,
  output result_t       result_next,
  output ramp_status_t  status
);

  level_t set_level, low_level, high_level, worst_error;
  logic   going_down, ramp_done, enable_on;
  mv_t    worst_set_mv, worst_read_mv;

  level_t set_level_next, low_level_next, high_level_next, worst_error_next;
  logic   going_down_next, ramp_done_next, enable_on_next;
  mv_t    worst_set_mv_next, worst_read_mv_next;

  volt_t  lo_volt, hi_volt, step_eff;
  level_t step_lvl, err;

  always_comb begin
    set_level_next     = set_level;
    low_level_next     = low_level;
    high_level_next    = high_level;
    worst_error_next   = worst_error;
    going_down_next    = going_down;
    ramp_done_next     = ramp_done;
    enable_on_next     = enable_on;
    worst_set_mv_next  = worst_set_mv;
    worst_read_mv_next = worst_read_mv;

    // bad bounds fall back to the full range
    if (cfg.min_volt > cfg.max_volt) begin
      lo_volt = '0;
      hi_volt = VOLT_BITS'(FULL_VOLT);
    end else begin
      lo_volt = cfg.min_volt;
      hi_volt = cfg.max_volt;
    end
    step_eff = (cfg.step_volt == '0) ? VOLT_BITS'(1) : cfg.step_volt;
    step_lvl = volt_to_level(step_eff);
    err      = (rd > set_level) ? rd - set_level : set_level - rd;

    if (cmd_t'(cmd) == CMD_START) begin
      low_level_next     = volt_to_level(lo_volt);
      high_level_next    = volt_to_level(hi_volt);
      set_level_next     = volt_to_level(lo_volt);
      going_down_next    = 1'b0;
      ramp_done_next     = 1'b0;
      enable_on_next     = 1'b1;
      worst_error_next   = '0;
      worst_set_mv_next  = '0;
      worst_read_mv_next = '0;
    end else if (!ramp_done) begin
      if (err > worst_error) begin
        worst_error_next   = err;
        worst_set_mv_next  = level_to_mv(set_level);
        worst_read_mv_next = level_to_mv(rd);
      end
      if (set_level >= high_level) going_down_next = 1'b1;
      if (going_down_next && set_level <= low_level) begin
        ramp_done_next = 1'b1;
        enable_on_next = 1'b0;
      end
      if (!going_down_next) begin
        if (set_level > high_level || (high_level - set_level) < step_lvl)
          set_level_next = high_level;
        else
          set_level_next = set_level + step_lvl;
      end else begin
        if (set_level < low_level || (set_level - low_level) < step_lvl)
          set_level_next = low_level;
        else
          set_level_next = set_level - step_lvl;
      end
    end

    result_next.dac_level     = set_level_next;
    result_next.hv_enable     = enable_on_next;
    result_next.worst_set_mv  = worst_set_mv_next;
    result_next.worst_read_mv = worst_read_mv_next;
    result_next.finished      = ramp_done_next;
    result_next.pass_flag     = (worst_error_next <= LEVEL_BITS'(PASS_LIMIT));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      set_level     <= '0;
      low_level     <= '0;
      high_level    <= '0;
      going_down    <= 1'b0;
      ramp_done     <= 1'b1;
      enable_on     <= 1'b0;
      worst_error   <= '0;
      worst_set_mv  <= '0;
      worst_read_mv <= '0;
    end else if (advance) begin
      set_level     <= set_level_next;
      low_level     <= low_level_next;
      high_level    <= high_level_next;
      going_down    <= going_down_next;
      ramp_done     <= ramp_done_next;
      enable_on     <= enable_on_next;
      worst_error   <= worst_error_next;
      worst_set_mv  <= worst_set_mv_next;
      worst_read_mv <= worst_read_mv_next;
    end
  end

  assign status.set_level  = set_level;
  assign status.low_level  = low_level;
  assign status.high_level = high_level;
  assign status.ramp_done  = ramp_done;
  assign status.enable_on  = enable_on;

endmodule

// ----- hdl/hvtrc_out_stage.sv -----
// result register with valid flag on the output stream
module hvtrc_out_stage import hvtrc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     load,
  input  result_t                  result_next,
  output logic                     can_load,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [OUT_DATA_BITS-1:0] m_tdata
);

  result_t result;

  assign can_load = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= result_next;
    end
  end

  assign m_tdata = OUT_DATA_BITS'(result);

endmodule

// ----- hdl/hv_triangle_ramp_checker.sv -----
// top level of the high-voltage triangle ramp checker
//
// usage:
//  - cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes min_volt (0),
//    max_volt (1) and step_volt (2); cfg_ready is always high, other indexes are
//    dropped; write only while no item is in flight
//  - s_ stream: s_tuser is the command (0 start ramp, 1 readback sample),
//    s_tdata carries the readback level in half-volt units
//  - m_ stream: one result item per input item, the level to drive next plus
//    enable, worst set/read pair in mV, finished and pass
//  - timing: the input register loads on the accept, the result register loads from
//    it through the combinational ramp update once it can take a result, and m_tvalid
//    rises with that load; throughput one item per cycle while the receiver does not stall
//  - when the receiver stalls the result register holds; one more item waits in
//    the input register, after which s_tready drops
//  - reset: bounds 0..2047 V, step 1 V, ramp idle (finished 1, enable 0),
//    worst values zero, both stream stages empty
`include "hv_triangle_ramp_checker_macros.svh"
module hv_triangle_ramp_checker import hvtrc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  // configuration write channel
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [VOLT_BITS-1:0]     cfg_data,
  // input stream
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [IN_DATA_BITS-1:0]  s_tdata,   // [11:0] readback_level, [15:12] zero
  input  logic                     s_tuser,   // [0] command
  // result stream
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [OUT_DATA_BITS-1:0] m_tdata    // [11:0] dac_level, [12] hv_enable,
                                              // [33:13] worst_set_mv,
                                              // [54:34] worst_read_mv,
                                              // [55] finished, [56] pass_flag,
                                              // [63:57] zero
);

  cfg_t         cfg;
  result_t      result_next;
  ramp_status_t status;

  // input register
  logic   in_valid;
  logic   in_cmd;
  level_t in_rd;
  logic   can_load;
  logic   advance;

  assign advance  = in_valid && can_load;
  assign s_tready = !in_valid || can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_cmd <= s_tuser;
      in_rd  <= s_tdata[RD_BITS-1:0];
    end
  end

  hvtrc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  hvtrc_ramp u_ramp (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .advance     (advance),
    .cmd         (in_cmd),
    .rd          (in_rd),
    .result_next (result_next),
    .status      (status)
  );

  hvtrc_out_stage u_out (
    .clk         (clk),
    .rst         (rst),
    .load        (advance),
    .result_next (result_next),
    .can_load    (can_load),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata)
  );

  // terms for the checks below
  logic flags_consistent;
  logic level_in_bounds;
  logic in_accept;

  assign flags_consistent = (status.enable_on != status.ramp_done);
  assign level_in_bounds  = (status.set_level >= status.low_level) &&
                            (status.set_level <= status.high_level);
  assign in_accept        = s_tvalid && s_tready;

  // enable and finished are always complementary
  `HVTRC_ASSERT_NOW(a_enable_vs_done, 1'b1, flags_consistent, "enable and finished disagree")

  // an active ramp keeps its level inside the latched bounds
  `HVTRC_ASSERT_NOW(a_level_in_bounds, !status.ramp_done, level_in_bounds, "level outside bounds")

  // an accepted item lands in the input register
  `HVTRC_ASSERT_NEXT(a_accept_lands, in_accept, in_valid, "accepted item lost")

  // a processed item always yields a result on the next cycle
  `HVTRC_ASSERT_NEXT(a_advance_result, advance, m_tvalid, "processed item produced no result")

endmodule

// ----- tb/sv/ramp_result_checker.sv -----
// ramp checker monitor: follows the cfg and stream channels, predicts every result item and compares
module ramp_result_checker import hvtrc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [VOLT_BITS-1:0]     cfg_data,
  input  logic                     s_tvalid,
  input  logic                     s_tready,
  input  logic [IN_DATA_BITS-1:0]  s_tdata,   // [11:0] readback_level, [15:12] zero
  input  logic                     s_tuser,   // [0] command
  input  logic                     m_tvalid,
  input  logic                     m_tready,
  input  logic [OUT_DATA_BITS-1:0] m_tdata,   // [11:0] dac_level, [12] hv_enable,
                                              // [33:13] worst_set_mv, [54:34] worst_read_mv,
                                              // [55] finished, [56] pass_flag, [63:57] zero
  output int                       fail_count,
  output int                       open_results,
  output int                       result_count,
  output int                       ramps_passed,
  output int                       ramps_failed
);

  // register copies
  volt_t   min_cfg, max_cfg, step_cfg;
  // ramp state
  level_t  set_lvl, low_lvl, high_lvl;
  logic    descending, idle, hv_on;
  level_t  worst_dev;
  mv_t     worst_set, worst_read;

  result_t due_results[$];
  int      mismatches, seen, passed, failed;

  function automatic result_t advance_ramp(cmd_t cmd, level_t readback);
    int      lo, hi, cur, lo_l, hi_l, stride, dev;
    result_t r;
    if (cmd == CMD_START) begin
      lo = int'(min_cfg);
      hi = int'(max_cfg);
      if (lo > hi) begin
        lo = 0;
        hi = FULL_VOLT;
      end
      low_lvl    = level_t'(lo * LEVELS_PER_VOLT);
      high_lvl   = level_t'(hi * LEVELS_PER_VOLT);
      set_lvl    = low_lvl;
      descending = 1'b0;
      idle       = 1'b0;
      hv_on      = 1'b1;
      worst_dev  = '0;
      worst_set  = '0;
      worst_read = '0;
    end else if (!idle) begin
      cur    = int'(set_lvl);
      lo_l   = int'(low_lvl);
      hi_l   = int'(high_lvl);
      stride = (step_cfg == '0 ? 1 : int'(step_cfg)) * LEVELS_PER_VOLT;
      dev    = int'(readback) > cur ? int'(readback) - cur : cur - int'(readback);
      if (dev > int'(worst_dev)) begin
        worst_dev  = level_t'(dev);
        worst_set  = mv_t'(cur * MV_PER_LEVEL);
        worst_read = mv_t'(int'(readback) * MV_PER_LEVEL);
      end
      if (cur >= hi_l) descending = 1'b1;
      if (descending && cur <= lo_l) begin
        idle  = 1'b1;
        hv_on = 1'b0;
        if (int'(worst_dev) <= PASS_LIMIT) passed++;
        else failed++;
      end
      if (!descending) cur = (cur > hi_l || hi_l - cur < stride) ? hi_l : cur + stride;
      else             cur = (cur < lo_l || cur - lo_l < stride) ? lo_l : cur - stride;
      set_lvl = level_t'(cur);
    end
    r.dac_level     = set_lvl;
    r.hv_enable     = hv_on;
    r.worst_set_mv  = worst_set;
    r.worst_read_mv = worst_read;
    r.finished      = idle;
    r.pass_flag     = (int'(worst_dev) <= PASS_LIMIT);
    return r;
  endfunction

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result %0d %s mismatch: expected %0d, got %0d", seen, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    result_t got, want;
    if (rst) begin
      min_cfg    = '0;
      max_cfg    = volt_t'(FULL_VOLT);
      step_cfg   = volt_t'(1);
      set_lvl    = '0;
      low_lvl    = '0;
      high_lvl   = '0;
      descending = 1'b0;
      idle       = 1'b1;
      hv_on      = 1'b0;
      worst_dev  = '0;
      worst_set  = '0;
      worst_read = '0;
      due_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MIN_VOLT:  min_cfg  = cfg_data;
          REG_MAX_VOLT:  max_cfg  = cfg_data;
          REG_STEP_VOLT: step_cfg = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready)
        due_results.push_back(advance_ramp(cmd_t'(s_tuser), level_t'(s_tdata[RD_BITS-1:0])));
      if (m_tvalid && m_tready) begin
        seen++;
        got = result_t'(m_tdata[$bits(result_t)-1:0]);
        if (due_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("result %0d arrived with no item waiting for it", seen);
        end else begin
          want = due_results.pop_front();
          check_field("dac_level", want.dac_level, got.dac_level);
          check_field("hv_enable", want.hv_enable, got.hv_enable);
          check_field("worst_set_mv", want.worst_set_mv, got.worst_set_mv);
          check_field("worst_read_mv", want.worst_read_mv, got.worst_read_mv);
          check_field("finished", want.finished, got.finished);
          check_field("pass_flag", want.pass_flag, got.pass_flag);
          check_field("padding", 0, m_tdata[OUT_DATA_BITS-1:$bits(result_t)]);
        end
      end
    end
    fail_count   <= mismatches;
    open_results <= due_results.size();
    result_count <= seen;
    ramps_passed <= passed;
    ramps_failed <= failed;
  end

endmodule

// ----- tb/sv/tb_hv_triangle_ramp_checker.sv -----
// testbench top for the high-voltage triangle ramp checker: clock, reset, stimulus and verdict
module tb_hv_triangle_ramp_checker;
  import hvtrc_pkg::*;

  localparam int     ITEM_TARGET  = 1950;
  localparam int     MAX_GAP      = 19;
  localparam int     DRAIN_CYCLES = 8;
  localparam longint RUN_LIMIT    = 10_000_000;

  logic                     clk;
  logic                     rst;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [VOLT_BITS-1:0]     cfg_data;
  logic                     s_tvalid;
  logic                     s_tready;
  logic [IN_DATA_BITS-1:0]  s_tdata;   // [11:0] readback_level, [15:12] zero
  logic                     s_tuser;   // [0] command
  logic                     m_tvalid;
  logic                     m_tready;
  logic [OUT_DATA_BITS-1:0] m_tdata;   // [11:0] dac_level, [12] hv_enable,
                                       // [33:13] worst_set_mv, [54:34] worst_read_mv,
                                       // [55] finished, [56] pass_flag, [63:57] zero

  int fail_count, open_results, result_count, ramps_passed, ramps_failed;
  int items_sent;
  // when set, both sides run back to back with no idle cycles
  bit calm;

  hv_triangle_ramp_checker u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  ramp_result_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .fail_count   (fail_count),
    .open_results (open_results),
    .result_count (result_count),
    .ramps_passed (ramps_passed),
    .ramps_failed (ramps_failed)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // idle cycles ahead of the next item on either side
  function automatic int draw_gap();
    return calm ? 0 : int'($urandom_range(0, MAX_GAP));
  endfunction

  // readback around the level the ramp should sit at, wider spread gives worse ramps
  function automatic level_t near_level(int aim, int spread);
    int v;
    if (spread >= 30 && $urandom_range(0, 9) == 0) v = $urandom_range(0, 4095);
    else v = aim + int'($urandom_range(0, 2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return level_t'(v);
  endfunction

  // present one item and hold it until accepted; valid stays high for back-to-back items
  task automatic send_item(cmd_t cmd, level_t readback);
    int gap;
    gap = draw_gap();
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= IN_DATA_BITS'(readback);
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  // stop sending and wait for every outstanding result
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (open_results != 0) @(posedge clk);
  endtask

  // leaves cfg_valid high so several writes can go back to back
  task automatic cfg_write(cfg_reg_t idx, volt_t value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_bounds(volt_t lo, volt_t hi, volt_t stride);
    drain();
    cfg_write(REG_MIN_VOLT, lo);
    cfg_write(REG_MAX_VOLT, hi);
    cfg_write(REG_STEP_VOLT, stride);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_step(volt_t stride);
    drain();
    cfg_write(REG_STEP_VOLT, stride);
    cfg_valid <= 1'b0;
  endtask

  // one ramp: start, then samples near the expected level until it is back at the bottom;
  // now and then a restart, a step change halfway or an abandoned ramp
  task automatic run_ramp(volt_t lo, volt_t hi, volt_t stride, int spread);
    int lo_l, hi_l, lvl, step_l, guard, pick;
    bit down, done;
    load_bounds(lo, hi, stride);
    send_item(CMD_START, level_t'($urandom_range(0, 4095)));
    // min above max falls back to the full range
    lo_l   = (lo > hi) ? 0 : 2 * int'(lo);
    hi_l   = (lo > hi) ? 2 * FULL_VOLT : 2 * int'(hi);
    lvl    = lo_l;
    step_l = 2 * (stride == '0 ? 1 : int'(stride));
    down   = 1'b0;
    done   = 1'b0;
    guard  = 0;
    while (!done && guard < 400) begin
      guard++;
      pick = $urandom_range(0, 99);
      if (pick == 0) begin
        // restart in the middle of the ramp
        send_item(CMD_START, level_t'($urandom_range(0, 4095)));
        lvl  = lo_l;
        down = 1'b0;
      end else if (pick == 1) begin
        // step change between samples, bounds stay latched
        stride = ($urandom_range(0, 3) == 0) ? volt_t'(0) : volt_t'($urandom_range(1, 64));
        load_step(stride);
        step_l = 2 * (stride == '0 ? 1 : int'(stride));
      end
      if (pick == 2) begin
        done = 1'b1;
      end else begin
        send_item(CMD_SAMPLE, near_level(lvl, spread));
        if (lvl >= hi_l) down = 1'b1;
        if (down && lvl <= lo_l) done = 1'b1;
        if (!down) lvl = (hi_l - lvl < step_l) ? hi_l : lvl + step_l;
        else       lvl = (lvl - lo_l < step_l) ? lo_l : lvl - step_l;
      end
    end
  endtask

  // receiver: random stall ahead of every result, ready held until the handshake
  initial begin
    int gap;
    m_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      gap = draw_gap();
      if (gap != 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  // hard stop if the block hangs
  initial begin
    #(RUN_LIMIT);
    $display("hv_triangle_ramp_checker test failed");
    $finish;
  end

  initial begin
    int kind, lo, hi, stride, eff, span, spread;
    rst       <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_index <= REG_MIN_VOLT;
    cfg_data  <= '0;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= CMD_START;
    calm       = 1'b0;
    items_sent = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed part
    // samples while idle report the reset state
    send_item(CMD_SAMPLE, '1);
    send_item(CMD_SAMPLE, '0);
    // default bounds, readback on a start is ignored
    send_item(CMD_START, '1);
    // largest possible deviation, then a small one that must not replace it
    send_item(CMD_SAMPLE, '1);
    send_item(CMD_SAMPLE, '0);
    // zero-width ramp at the very top
    load_bounds(volt_t'(2047), volt_t'(2047), volt_t'(2047));
    send_item(CMD_START, '0);
    send_item(CMD_SAMPLE, level_t'(4094));
    send_item(CMD_SAMPLE, '0);
    // one full step each way; four levels off still passes, five fails
    load_bounds(volt_t'(0), volt_t'(2047), volt_t'(2047));
    send_item(CMD_START, '0);
    send_item(CMD_SAMPLE, '0);
    send_item(CMD_SAMPLE, level_t'(4090));
    send_item(CMD_SAMPLE, level_t'(5));
    // min above max with a zero step
    load_bounds(volt_t'(9), volt_t'(3), volt_t'(0));
    send_item(CMD_START, '1);
    send_item(CMD_SAMPLE, level_t'(1));
    send_item(CMD_SAMPLE, level_t'(2));
    // step raised mid-ramp, clamps at both ends
    load_step(volt_t'(2047));
    send_item(CMD_SAMPLE, level_t'(4));
    send_item(CMD_SAMPLE, level_t'(4094));
    send_item(CMD_SAMPLE, '0);
    // restart while a ramp is running
    send_item(CMD_START, level_t'(1234));
    send_item(CMD_SAMPLE, level_t'(3));
    send_item(CMD_START, '0);
    send_item(CMD_SAMPLE, level_t'(2048));

    // random part: mostly complete ramps, some stray items
    while (items_sent < ITEM_TARGET) begin
      calm = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 19);
      if (kind == 0) begin
        repeat ($urandom_range(1, 4))
          send_item(cmd_t'($urandom_range(0, 1)), level_t'($urandom_range(0, 4095)));
      end else begin
        if (kind == 1) begin
          // bounds swapped, large step keeps the full-range ramp short
          stride = $urandom_range(150, 2047);
          lo     = $urandom_range(1, 2047);
          hi     = $urandom_range(0, lo - 1);
        end else begin
          if ($urandom_range(0, 7) == 0) stride = 0;
          else if ($urandom_range(0, 9) == 0) stride = $urandom_range(65, 2047);
          else stride = $urandom_range(1, 64);
          eff  = (stride == 0) ? 1 : stride;
          span = eff * int'($urandom_range(0, 12)) + int'($urandom_range(0, eff));
          if (span > 2047) span = 2047;
          case ($urandom_range(0, 5))
            0:       lo = 0;
            1:       lo = 2047 - span;
            default: lo = $urandom_range(0, 2047 - span);
          endcase
          hi = lo + span;
        end
        case ($urandom_range(0, 3))
          0:       spread = 2;
          1:       spread = 4;
          2:       spread = 5;
          default: spread = 30;
        endcase
        run_ramp(volt_t'(lo), volt_t'(hi), volt_t'(stride), spread);
        // a sample after the ramp, which changes nothing if the ramp has ended
        if (kind < 4) send_item(CMD_SAMPLE, level_t'($urandom_range(0, 4095)));
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("sent %0d items, checked %0d results", items_sent, result_count);
    $display("ramps run to the bottom: %0d within limit, %0d over", ramps_passed, ramps_failed);
    if (fail_count == 0 && open_results == 0) begin
      $display("hv_triangle_ramp_checker test passed");
    end else begin
      $display("hv_triangle_ramp_checker test failed");
    end
    $finish;
  end

endmodule
